FILE: design/text_telemetry_line_parser_macros.svh
// Assertion macros used by the checker of the line parser.
// Each macro samples on the rising edge of i_clk and is off while reset is held.
`ifndef TEXT_TELEMETRY_LINE_PARSER_MACROS_SVH
`define TEXT_TELEMETRY_LINE_PARSER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TTLP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TTLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ttlp_pkg.sv
package ttlp_pkg;

    typedef logic [3:0]  t_label_code;
    typedef logic [1:0]  t_scale_code;
    typedef logic [23:0] t_label_chars;
    typedef logic [2:0]  t_label_len;

    // Parse modes.
    localparam logic [1:0] MODE_WAIT   = 2'd0;
    localparam logic [1:0] MODE_LABEL  = 2'd1;
    localparam logic [1:0] MODE_VSTART = 2'd2;
    localparam logic [1:0] MODE_REST   = 2'd3;

    // Characters with a role in the line format.
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    // Scale codes: the reading is to be divided by one, hundred or thousand.
    localparam t_scale_code SCALE_ONE      = 2'd0;
    localparam t_scale_code SCALE_HUNDRED  = 2'd1;
    localparam t_scale_code SCALE_THOUSAND = 2'd2;

    localparam int unsigned NUM_LABELS = 12;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

    typedef struct packed {
        t_label_chars chars;
        t_label_len   len;
        t_scale_code  scale;
    } t_label_entry;

    // Known labels, newest byte in the low byte, in label-code order.
    localparam t_label_entry LABEL_TABLE [NUM_LABELS] = '{
        '{24'h000056, 3'd1, SCALE_THOUSAND},  // V
        '{24'h565056, 3'd3, SCALE_THOUSAND},  // VPV
        '{24'h505056, 3'd3, SCALE_ONE},       // PPV
        '{24'h000049, 3'd1, SCALE_THOUSAND},  // I
        '{24'h00494C, 3'd2, SCALE_THOUSAND},  // IL
        '{24'h483139, 3'd3, SCALE_HUNDRED},   // H19
        '{24'h483230, 3'd3, SCALE_HUNDRED},   // H20
        '{24'h483231, 3'd3, SCALE_ONE},       // H21
        '{24'h483232, 3'd3, SCALE_HUNDRED},   // H22
        '{24'h483233, 3'd3, SCALE_ONE},       // H23
        '{24'h455252, 3'd3, SCALE_ONE},       // ERR
        '{24'h004353, 3'd2, SCALE_ONE}        // CS
    };

    typedef struct packed {
        logic        hit;
        t_label_code code;
        t_scale_code scale;
    } t_match;

endpackage

FILE: design/ttlp_label_match.sv
module ttlp_label_match (
    input  ttlp_pkg::t_label_chars i_chars,
    input  ttlp_pkg::t_label_len   i_len,
    output ttlp_pkg::t_match       o_match
);
    import ttlp_pkg::*;

    // Labels are distinct, so at most one entry hits; the lowest code wins anyway.
    always_comb begin
        o_match = '0;
        for (int k = NUM_LABELS - 1; k >= 0; k--) begin
            if (LABEL_TABLE[k].len == i_len && LABEL_TABLE[k].chars == i_chars) begin
                o_match.hit   = 1'b1;
                o_match.code  = t_label_code'(k);
                o_match.scale = LABEL_TABLE[k].scale;
            end
        end
    end

endmodule

FILE: design/text_telemetry_line_parser.sv
// Text telemetry line parser.
// Input channel: one received character per word on i_rx_byte, handshaked by
// i_rx_valid / o_rx_ready. Lines are split into terms by tab or comma and end
// at CR or LF. A line whose first term is a known label and whose second term
// holds at least one decimal digit yields one result word on the output
// channel (o_res_valid / i_res_ready): the label code, the signed reading
// saturated to 32 bits, and the power of ten it is to be divided by.
// Each character is handled in the cycle it is accepted, so the block takes a
// character every cycle unless stalled. A result appears the cycle after the
// accepted line terminator and sits in a single output register. While that
// register holds an untaken result and the receiver stalls, o_rx_ready is low;
// when the receiver takes the result, a new character is accepted in the same
// cycle. After reset the parser ignores characters until the first LF, so a
// line caught halfway through is never reported. Lines longer than LINE_LENGTH
// characters or with more than TERM_LIMIT separators are dropped the same way.
module text_telemetry_line_parser #(
    parameter int unsigned LINE_LENGTH = 128,
    parameter int unsigned TERM_LIMIT  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rx_valid,
    output logic                   o_rx_ready,
    input  logic [7:0]             i_rx_byte,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output ttlp_pkg::t_label_code  o_label_code,
    output logic signed [31:0]     o_reading,
    output ttlp_pkg::t_scale_code  o_scale_code
);
    import ttlp_pkg::*;

    localparam int unsigned LINE_W = $clog2(LINE_LENGTH + 1);
    localparam int unsigned TERM_W = $clog2(TERM_LIMIT + 1);

    // Line state.
    logic [1:0]        r_mode,      n_mode;
    t_label_chars      r_chars,     n_chars;
    t_label_len        r_label_len, n_label_len;
    logic [TERM_W-1:0] r_terms,     n_terms;
    logic [LINE_W-1:0] r_line_len,  n_line_len;
    logic [31:0]       r_accum,     n_accum;
    logic              r_neg,       n_neg;
    logic              r_digit,     n_digit;
    logic              r_stopped,   n_stopped;

    // Result register.
    logic              r_out_valid, n_out_valid;
    t_label_code       r_code,      n_code;
    logic [31:0]       r_reading,   n_reading;
    t_scale_code       r_scale,     n_scale;

    logic              accept;
    logic              emit;
    logic              is_sep, is_term, is_digit;
    logic [3:0]        digit;
    logic [35:0]       times_ten;
    logic [31:0]       accum_step;
    t_match            match;

    assign o_rx_ready = !r_out_valid || i_res_ready;
    assign accept     = i_rx_valid && o_rx_ready;

    assign is_sep   = (i_rx_byte == CHR_COMMA) || (i_rx_byte == CHR_TAB);
    assign is_term  = (i_rx_byte == CHR_CR) || (i_rx_byte == CHR_LF);
    assign is_digit = (i_rx_byte >= CHR_ZERO) && (i_rx_byte <= CHR_NINE);
    assign digit    = 4'(i_rx_byte - CHR_ZERO);

    // Magnitude times ten plus the digit, held at 2^31 so negation stays exact.
    assign times_ten  = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) + 36'(digit);
    assign accum_step = (times_ten > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : times_ten[31:0];

    ttlp_label_match u_match (
        .i_chars (r_chars),
        .i_len   (r_label_len),
        .o_match (match)
    );

    always_comb begin
        n_mode      = r_mode;
        n_chars     = r_chars;
        n_label_len = r_label_len;
        n_terms     = r_terms;
        n_line_len  = r_line_len;
        n_accum     = r_accum;
        n_neg       = r_neg;
        n_digit     = r_digit;
        n_stopped   = r_stopped;
        emit        = 1'b0;

        if (accept) begin
            if (r_mode == MODE_WAIT || is_term) begin
                // A terminator closes the line; while waiting only LF opens one.
                if (r_mode != MODE_WAIT || i_rx_byte == CHR_LF) begin
                    emit        = (r_mode != MODE_WAIT) && match.hit && r_digit;
                    n_mode      = MODE_LABEL;
                    n_chars     = '0;
                    n_label_len = '0;
                    n_terms     = '0;
                    n_line_len  = '0;
                    n_accum     = '0;
                    n_neg       = 1'b0;
                    n_digit     = 1'b0;
                    n_stopped   = 1'b0;
                end
            end else if (r_line_len == LINE_W'(LINE_LENGTH)) begin
                n_mode = MODE_WAIT;
            end else begin
                n_line_len = r_line_len + 1'b1;
                if (is_sep) begin
                    if (r_terms == TERM_W'(TERM_LIMIT)) begin
                        n_mode = MODE_WAIT;
                    end else begin
                        n_terms = r_terms + 1'b1;
                        n_mode  = (r_terms == '0) ? MODE_VSTART : MODE_REST;
                    end
                end else begin
                    case (r_mode)
                        MODE_LABEL: begin
                            n_chars = {r_chars[15:0], i_rx_byte};
                            if (r_label_len < 3'd4) begin
                                n_label_len = r_label_len + 1'b1;
                            end
                        end
                        MODE_VSTART: begin
                            if (i_rx_byte == CHR_MINUS) begin
                                n_neg = 1'b1;
                            end else if (is_digit) begin
                                n_accum = accum_step;
                                n_digit = 1'b1;
                            end else if (i_rx_byte != CHR_PLUS) begin
                                n_stopped = 1'b1;
                            end
                            n_mode = MODE_REST;
                        end
                        default: begin
                            // Only the value term is read; later terms are skipped.
                            if (r_terms == TERM_W'(1) && !r_stopped) begin
                                if (is_digit) begin
                                    n_accum = accum_step;
                                    n_digit = 1'b1;
                                end else begin
                                    n_stopped = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_comb begin
        n_out_valid = emit || (r_out_valid && !i_res_ready);
        n_code      = r_code;
        n_reading   = r_reading;
        n_scale     = r_scale;
        if (emit) begin
            n_code  = match.code;
            n_scale = match.scale;
            if (r_neg) begin
                n_reading = 32'd0 - r_accum;
            end else begin
                n_reading = (r_accum > POS_LIMIT) ? POS_LIMIT : r_accum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_WAIT;
            r_chars     <= '0;
            r_label_len <= '0;
            r_terms     <= '0;
            r_line_len  <= '0;
            r_accum     <= '0;
            r_neg       <= 1'b0;
            r_digit     <= 1'b0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_chars     <= n_chars;
            r_label_len <= n_label_len;
            r_terms     <= n_terms;
            r_line_len  <= n_line_len;
            r_accum     <= n_accum;
            r_neg       <= n_neg;
            r_digit     <= n_digit;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_reading <= n_reading;
        r_scale   <= n_scale;
    end

    assign o_res_valid  = r_out_valid;
    assign o_label_code = r_code;
    assign o_reading    = signed'(r_reading);
    assign o_scale_code = r_scale;

endmodule

FILE: design/ttlp_checker.sv
`include "text_telemetry_line_parser_macros.svh"

module ttlp_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_rx_valid,
    input logic                  o_rx_ready,
    input logic [7:0]            i_rx_byte,
    input logic                  o_res_valid,
    input logic                  i_res_ready,
    input ttlp_pkg::t_label_code o_label_code,
    input logic signed [31:0]    o_reading,
    input ttlp_pkg::t_scale_code o_scale_code
);
    import ttlp_pkg::*;

    // A result word carries a real label and scale.
    `TTLP_ASSERT_SAME(a_codes_in_range, o_res_valid, (o_label_code <= 4'd11) && (o_scale_code <= SCALE_THOUSAND), "result code out of range")

    // Exactly H19, H20 and H22 are scaled by one hundred.
    `TTLP_ASSERT_SAME(a_hundred_scale, o_res_valid, ((o_label_code == 4'd5) || (o_label_code == 4'd6) || (o_label_code == 4'd8)) == (o_scale_code == SCALE_HUNDRED), "scale does not fit label")

    // A result word only follows an accepted line terminator.
    `TTLP_ASSERT_SAME(a_result_after_eol, $rose(o_res_valid), $past(i_rx_valid && o_rx_ready && ((i_rx_byte == CHR_CR) || (i_rx_byte == CHR_LF))), "result without line end")

    // A stalled result word holds.
    `TTLP_ASSERT_NEXT(a_result_holds, o_res_valid && !i_res_ready, o_res_valid && $stable(o_reading) && $stable(o_label_code) && $stable(o_scale_code), "stalled result changed")

endmodule

bind text_telemetry_line_parser ttlp_checker u_ttlp_checker (.*);

FILE: dv/text_telemetry_line_parser_tb.sv
`timescale 1ns / 100ps

module text_telemetry_line_parser_tb;

    import ttlp_pkg::*;

    // The block is built with its default limits; the line tracker below uses the same ones.
    localparam int MAX_LINE_CHARS = 128;
    localparam int MAX_SEPARATORS = 16;

    // Reading words carried on the result channel.
    typedef struct {
        t_label_code        code;
        logic signed [31:0] reading;
        t_scale_code        scale;
    } t_reading;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_rx_valid  = 1'b0;
    logic [7:0]         i_rx_byte   = 8'h00;
    logic               i_res_ready = 1'b0;
    logic               o_rx_ready;
    logic               o_res_valid;
    t_label_code        o_label_code;
    logic signed [31:0] o_reading;
    t_scale_code        o_scale_code;

    text_telemetry_line_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_label_code (o_label_code),
        .o_reading    (o_reading),
        .o_scale_code (o_scale_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The twelve labels in label-code order, with the power of ten each reading is scaled by.
    string known_labels [12] = '{"V", "VPV", "PPV", "I", "IL", "H19", "H20", "H21", "H22",
                                 "H23", "ERR", "CS"};
    t_scale_code known_scales [12] = '{SCALE_THOUSAND, SCALE_THOUSAND, SCALE_ONE,
                                       SCALE_THOUSAND, SCALE_THOUSAND, SCALE_HUNDRED,
                                       SCALE_HUNDRED, SCALE_ONE, SCALE_HUNDRED, SCALE_ONE,
                                       SCALE_ONE, SCALE_ONE};

    // ------------------------------------------------------------------
    // Line tracker: follows the character stream the same way the parser
    // must, and queues the reading word each finished line should produce.
    // ------------------------------------------------------------------
    logic [1:0]  line_mode    = MODE_WAIT;
    logic [23:0] line_label   = '0;
    int          line_label_len;
    int          line_seps;
    int          line_len;
    logic [31:0] line_mag     = '0;
    bit          line_neg;
    bit          line_digit;
    bit          line_stopped;

    t_reading expected_readings [$];
    t_reading oldest;

    // Run statistics and control shared between the test tasks and the side processes.
    int          mismatch_count;
    int          line_chars_taken;
    int          results_checked;
    int          rx_stall_cycles;
    logic [11:0] labels_seen = '0;
    bit          rx_idle_en  = 1'b1;
    bit          res_idle_en = 1'b1;
    int          res_hold_request;
    int          res_hold_left;
    int          res_gap_left;

    function automatic logic [23:0] pack_label(input string s);
        logic [23:0] v;
        v = '0;
        for (int i = 0; i < s.len(); i++) v = {v[15:0], s[i]};
        return v;
    endfunction

    function automatic void clear_line();
        line_label     = '0;
        line_label_len = 0;
        line_seps      = 0;
        line_len       = 0;
        line_mag       = '0;
        line_neg       = 1'b0;
        line_digit     = 1'b0;
        line_stopped   = 1'b0;
    endfunction

    // Magnitude grows by one decimal digit and sticks at 2^31 once it gets there.
    function automatic void take_digit(input logic [7:0] c);
        logic [35:0] m;
        m          = line_mag * 36'd10 + (c - CHR_ZERO);
        line_mag   = (m > MAG_LIMIT) ? MAG_LIMIT : m[31:0];
        line_digit = 1'b1;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CHR_ZERO && c <= CHR_NINE;
    endfunction

    task automatic parse_char(input logic [7:0] c);
        t_reading r;
        int       code;
        // Until an LF arrives nothing is looked at, a CR included.
        if (line_mode == MODE_WAIT) begin
            if (c == CHR_LF) begin
                clear_line();
                line_mode = MODE_LABEL;
            end
            return;
        end
        // A terminator closes the line; a known label with at least one digit gives a word.
        if (c == CHR_CR || c == CHR_LF) begin
            code = -1;
            if (line_digit && line_label_len >= 1 && line_label_len <= 3) begin
                for (int k = 0; k < 12; k++) begin
                    if (code < 0 && known_labels[k].len() == line_label_len &&
                        pack_label(known_labels[k]) == line_label) begin
                        code = k;
                    end
                end
            end
            if (code >= 0) begin
                r.code    = code[3:0];
                r.reading = line_neg ? (32'd0 - line_mag)
                                     : ((line_mag > POS_LIMIT) ? POS_LIMIT : line_mag);
                r.scale   = known_scales[code];
                expected_readings.push_back(r);
            end
            clear_line();
            line_mode = MODE_LABEL;
            return;
        end
        // Overlong line: dropped, and the parser goes back to hunting for LF.
        if (line_len >= MAX_LINE_CHARS) begin
            line_mode = MODE_WAIT;
            return;
        end
        line_len++;
        if (c == CHR_COMMA || c == CHR_TAB) begin
            if (line_seps >= MAX_SEPARATORS) begin
                line_mode = MODE_WAIT;
                return;
            end
            line_seps++;
            line_mode = (line_seps == 1) ? MODE_VSTART : MODE_REST;
            return;
        end
        if (line_mode == MODE_LABEL) begin
            line_label = {line_label[15:0], c};
            if (line_label_len < 4) line_label_len++;
        end else if (line_mode == MODE_VSTART) begin
            if (c == CHR_MINUS) line_neg = 1'b1;
            else if (is_digit(c)) take_digit(c);
            else if (c != CHR_PLUS) line_stopped = 1'b1;
            line_mode = MODE_REST;
        end else if (line_seps == 1 && !line_stopped) begin
            if (is_digit(c)) take_digit(c);
            else line_stopped = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Monitor: sampled at the rising edge, so every value seen here is the
    // one the block itself saw at that edge. A result word is checked before
    // the character of the same edge is tracked; a result is registered, so it
    // always trails its terminator and the order cannot matter.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_valid && i_res_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("reading word with no line pending: label %0d %0d",
                                              o_label_code, o_reading));
                end else begin
                    oldest = expected_readings.pop_front();
                    if (o_label_code !== oldest.code)
                        report_mismatch($sformatf("label code %0d, want %0d",
                                                  o_label_code, oldest.code));
                    if (o_reading !== oldest.reading)
                        report_mismatch($sformatf("reading %0d, want %0d (label %0d)",
                                                  o_reading, oldest.reading, oldest.code));
                    if (o_scale_code !== oldest.scale)
                        report_mismatch($sformatf("scale code %0d, want %0d (label %0d)",
                                                  o_scale_code, oldest.scale, oldest.code));
                    results_checked++;
                    labels_seen[oldest.code] = 1'b1;
                end
            end
            if (i_rx_valid && !o_rx_ready) rx_stall_cycles++;
            if (i_rx_valid && o_rx_ready) begin
                // Characters dropped while hunting for LF do not count as parsed.
                if (line_mode != MODE_WAIT) line_chars_taken++;
                parse_char(i_rx_byte);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver. A hold-off asked for by a test takes priority; other
    // than that the receiver stalls in random bursts while idling is enabled.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (res_hold_request > 0) begin
            res_hold_left    = res_hold_request;
            res_hold_request = 0;
        end
        if (res_hold_left > 0) begin
            res_hold_left--;
            i_res_ready <= 1'b0;
        end else if (res_gap_left > 0) begin
            res_gap_left--;
            i_res_ready <= 1'b0;
        end else if (res_idle_en && $urandom_range(0, 5) == 0) begin
            res_gap_left = $urandom_range(0, 3);
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Character sender. Every call starts and ends at a rising edge. Valid
    // is left high after the word is taken so that the next call can follow
    // without a bubble; it is only lowered for an idle burst or a drain.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c);
        if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            i_rx_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= c;
        do @(posedge i_clk); while (!o_rx_ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Stops offering characters and waits until every pending reading has come back.
    task automatic wait_results();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_readings.size() > 0) @(posedge i_clk);
    endtask

    // A line right at a limit, or just past it. By separators: "V,5" and then
    // more separators up to the count. By length: "V" TAB and nines filling
    // the line to the given number of characters.
    task automatic send_limit_line(input bit by_seps, input int count, input logic [7:0] term);
        if (by_seps) begin
            send_text("V,5");
            repeat (count - 1) send_byte(CHR_COMMA);
        end else begin
            send_text("V\t");
            repeat (count - 2) send_byte("9");
        end
        send_byte(term);
    endtask

    task automatic send_random_line();
        string pool_label;
        string pool_junk;
        int    kind;
        int    ndig;
        pool_label = "VPIHLERCS0123v";
        pool_junk  = "VPIHLERCS0123456789+-.\t, x";
        kind       = $urandom_range(0, 99);
        if (kind < 72) begin
            // Well-formed shape: label, separator, optional sign, digits.
            if ($urandom_range(0, 9) != 0) begin
                send_text(known_labels[$urandom_range(0, 11)]);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(pool_label[$urandom_range(0, pool_label.len() - 1)]);
            end
            send_byte($urandom_range(0, 1) ? CHR_TAB : CHR_COMMA);
            case ($urandom_range(0, 5))
                0: send_byte(CHR_MINUS);
                1: send_byte(CHR_PLUS);
                default: ;
            endcase
            ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 6);
            repeat (ndig) send_byte(8'($urandom_range(CHR_ZERO, CHR_NINE)));
            if ($urandom_range(0, 4) == 0) begin
                send_byte(".");
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(CHR_ZERO, CHR_NINE)));
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte($urandom_range(0, 1) ? CHR_TAB : CHR_COMMA);
                    repeat ($urandom_range(0, 4))
                        send_byte(pool_junk[$urandom_range(0, pool_junk.len() - 1)]);
                end
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_byte(CHR_LF);
                5, 6, 7: begin
                    send_byte(CHR_CR);
                    send_byte(CHR_LF);
                end
                default: send_byte(CHR_CR);
            endcase
        end else if (kind < 86) begin
            // Broken lines built from the characters that matter to the parser.
            repeat ($urandom_range(1, 12))
                send_byte(pool_junk[$urandom_range(0, pool_junk.len() - 1)]);
            send_byte(CHR_LF);
        end else if (kind < 96) begin
            // Raw noise over the whole byte range.
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
            send_byte(CHR_LF);
        end else begin
            send_limit_line(1'($urandom_range(0, 1)),
                            $urandom_range(0, 1) ? MAX_SEPARATORS + $urandom_range(0, 2)
                                                 : MAX_LINE_CHARS + $urandom_range(0, 2),
                            CHR_LF);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Out of reset the parser is mid-stream: a whole line with a CR, stray
    // characters and a CR alone must all pass unseen until the first LF.
    task automatic test_startup_resync();
        send_text("V\t5\015");
        send_text("VPV,77\015junk");
        send_byte(CHR_CR);
        send_byte(CHR_LF);
        send_text("V\t1\n");
        wait_results();
    endtask

    task automatic test_every_label();
        send_text("V\t12800\n");
        send_text("VPV\t-1\n");
        send_text("PPV,+7\n");
        send_text("I\t0\n");
        send_text("IL\t-1500\n");
        send_text("H19\t123456\n");
        send_text("H20\t99\n");
        send_text("H21\t-42\n");
        send_text("H22\t7\n");
        send_text("H23\t65535\n");
        send_text("ERR\t0\n");
        send_text("CS\t3\n");
    endtask

    // Saturation at both ends, truncated fractions, leading zeros, negative zero.
    task automatic test_value_extremes();
        send_text("V\t2147483647\n");
        send_text("V\t2147483648\n");
        send_text("VPV\t-2147483648\n");
        send_text("I\t-99999999999\n");
        send_text("H19\t99999999999999\n");
        send_text("I\t12.75\n");
        send_text("PPV\t00042\n");
        send_text("H21\t5x7\n");
        send_text("VPV\t-0\n");
        send_text("V\t1-2\n");
    endtask

    // Lines that end quietly, mixed with a few that must still report.
    task automatic test_corner_lines();
        send_text("V\tabc\n");
        send_text("V\t-\n");
        send_text("VPV\t--5\n");
        send_text("V\t+-3\n");
        send_text("CS\t+\t9\n");
        send_text("v\t5\n");
        send_text("VV\t5\n");
        send_text("VPVX\t5\n");
        send_text("XVPV\t5\n");
        send_text("\t5\n");
        // A zero byte is an ordinary label character and never matches.
        send_byte("V");
        send_byte(8'h00);
        send_text("\t5\n");
        send_byte(CHR_LF);
        send_text("\015\n");
        send_text("V\n");
        send_text("V\t5\015");
        // Trailing terms are counted for length and otherwise ignored.
        send_text("H20\t12\tFOO,");
        send_byte(8'hFF);
        send_byte(CHR_LF);
        wait_results();
    endtask

    // Lines exactly at the length and separator limits pass; one more drops them.
    task automatic test_line_limits();
        send_limit_line(1'b0, MAX_LINE_CHARS, CHR_LF);
        send_limit_line(1'b0, MAX_LINE_CHARS + 1, CHR_LF);
        send_text("I\t4\n");
        send_limit_line(1'b1, MAX_SEPARATORS, CHR_LF);
        send_limit_line(1'b1, MAX_SEPARATORS + 1, CHR_LF);
        send_text("IL\t6\n");
        // A dropped line closed by CR leaves the parser hunting, so the next line is lost too.
        send_limit_line(1'b1, MAX_SEPARATORS + 1, CHR_CR);
        send_text("V\t8\n");
        send_text("H22\t9\n");
        wait_results();
    endtask

    // The receiver stops for a long stretch while short lines keep coming, so the
    // output register fills and the input side has to stall until it is released.
    task automatic test_output_backpressure();
        res_hold_request = 300;
        repeat (12) send_text($sformatf("I\t-%0d\n", $urandom_range(0, 9)));
        wait_results();
    endtask

    // Traffic in bursts, the sender going quiet until every reading is back.
    task automatic test_drain_pause();
        repeat (3) begin
            repeat (4) send_random_line();
            wait_results();
        end
    endtask

    task automatic test_random_traffic(input int chars);
        int start;
        start = line_chars_taken;
        while (line_chars_taken - start < chars) send_random_line();
    endtask

    // Last stretch: both sides run flat out, no idling anywhere.
    task automatic test_back_to_back();
        rx_idle_en  = 1'b0;
        res_idle_en = 1'b0;
        repeat (12) send_random_line();
        wait_results();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_startup_resync();
        test_every_label();
        test_value_extremes();
        test_corner_lines();
        test_line_limits();
        test_output_backpressure();
        test_drain_pause();
        test_random_traffic(120);
        test_back_to_back();

        // The result comes in the cycle after its terminator; leave room for anything spurious.
        wait_results();
        repeat (8) @(posedge i_clk);

        $display("Summary: %0d line characters parsed, %0d readings checked, %0d of 12 labels.",
                 line_chars_taken, results_checked, $countones(labels_seen));
        $display("Summary: input held off for %0d cycles behind a full result register.",
                 rx_stall_cycles);
        if (mismatch_count == 0) begin
            $display("text_telemetry_line_parser_tb passed");
        end else begin
            $display("text_telemetry_line_parser_tb failed");
        end
        $finish;
    end

    // Watchdog: a correct run needs a small fraction of this.
    initial begin
        #2_000_000;
        $display("Timeout with %0d readings still pending.", expected_readings.size());
        $display("text_telemetry_line_parser_tb failed");
        $finish;
    end

endmodule
